/* sv/tkst_pkg.sv */
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types and constants for the top-k score table.
// ----------------------------------------------------------------------------
package tkst_pkg;

   localparam int SCORE_W     = 32;
   localparam int NAME_LOW_W  = 64;
   localparam int NAME_MID_W  = 64;
   localparam int NAME_HIGH_W = 32;
   localparam int INDEX_W     = 4;
   localparam int RANK_W      = 4;

   // request tdata: entry_index, new_score, new_name_low/mid/high, padded
   localparam int REQ_DATA_W = 200;
   // response tdata: placed_rank, in_top_ten, read_score, read_name_*, padded
   localparam int RSP_DATA_W = 200;

   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   // "empty" packed low byte first
   localparam logic [NAME_LOW_W-1:0] EMPTY_TEXT = 64'h0000_0079_7470_6D65;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [NAME_LOW_W-1:0]     name_low;
      logic [NAME_MID_W-1:0]     name_mid;
      logic [NAME_HIGH_W-1:0]    name_high;
   } entry_type;

   // control that every cell of the chain sees
   typedef struct packed {
      logic insert;     // an insert beat is accepted this cycle
      logic prev_keep;  // the upper neighbor keeps its entry
      logic last;       // this cell holds the lowest slot
   } cell_ctrl_type;

endpackage

/* sv/top_k_score_table.sv */
// ----------------------------------------------------------------------------
// top_k_score_table
// High-score table kept in descending order in a chain of slot cells.
// ----------------------------------------------------------------------------
// Every request beat gives one response beat: an insert
// compares the new score against all slots at once and each cell keeps its
// entry, takes the new one or takes its upper neighbor's in the same edge; a
// read selects one slot. The response sits in an output register, so a new
// beat is taken each cycle as long as the response side keeps up. Equal
// scores place the new entry below the existing ones; the lowest entry is
// dropped. Reads past the table return zero.
module top_k_score_table #(
   parameter int TABLE_SLOTS = 11
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // low to high: entry_index[3:0], new_score[35:4], new_name_low[99:36],
   // new_name_mid[163:100], new_name_high[195:164], zero pad
   input  logic [tkst_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // low to high: placed_rank[3:0], in_top_ten[4], read_score[36:5],
   // read_name_low[100:37], read_name_mid[164:101], read_name_high[196:165]
   output logic [tkst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int WIDE_W = (SLOT_W + 1 > 4) ? SLOT_W + 1 : 4;

   tkst_pkg::entry_type     new_entry;
   tkst_pkg::entry_type     slot_entry [TABLE_SLOTS];
   tkst_pkg::cell_ctrl_type slot_ctrl  [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0]  keep_vec;
   logic [TABLE_SLOTS-1:0]  place_vec;

   logic                         req_fire;
   logic                         is_insert;
   logic [tkst_pkg::INDEX_W-1:0] entry_index;
   logic [WIDE_W-1:0]            rank_wide;
   logic [WIDE_W-1:0]            index_wide;
   logic [tkst_pkg::RANK_W-1:0]  placed_rank;
   logic                         in_top_ten;
   tkst_pkg::entry_type          read_entry;

   logic                            rsp_tvalid_ff;
   logic                            rsp_tvalid_in;
   logic [tkst_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [tkst_pkg::RSP_DATA_W-1:0] rsp_tdata_in;

   assign req_tready  = !rsp_tvalid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign is_insert   = (tkst_pkg::opcode_type'(req_tuser) == tkst_pkg::OP_INSERT);
   assign entry_index = req_tdata[3:0];

   assign new_entry.score     = req_tdata[35:4];
   assign new_entry.name_low  = req_tdata[99:36];
   assign new_entry.name_mid  = req_tdata[163:100];
   assign new_entry.name_high = req_tdata[195:164];

   for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
      assign slot_ctrl[i].insert    = req_fire && is_insert;
      assign slot_ctrl[i].prev_keep = (i == 0) ? 1'b1 : keep_vec[(i == 0) ? 0 : i - 1];
      assign slot_ctrl[i].last      = (i == TABLE_SLOTS - 1);
      assign place_vec[i]           = slot_ctrl[i].prev_keep && !keep_vec[i];

      tkst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (slot_ctrl[i]),
         .new_entry  (new_entry),
         .prev_entry (slot_entry[(i == 0) ? 0 : i - 1]),
         .entry_out  (slot_entry[i]),
         .keep_out   (keep_vec[i])
      );
   end

   // exactly one cell sits at the keep boundary; its position is the rank
   always_comb begin
      rank_wide = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (place_vec[i]) begin
            rank_wide = rank_wide | WIDE_W'(i);
         end
      end
   end

   assign placed_rank = (rank_wide > WIDE_W'(tkst_pkg::RANK_MAX)) ? tkst_pkg::RANK_MAX
                                                                  : rank_wide[3:0];
   assign in_top_ten  = !place_vec[TABLE_SLOTS-1];

   assign index_wide = WIDE_W'(entry_index);

   always_comb begin
      read_entry = '0;
      if (index_wide < WIDE_W'(TABLE_SLOTS)) begin
         read_entry = slot_entry[index_wide[SLOT_W-1:0]];
      end
   end

   always_comb begin
      rsp_tdata_in = '0;
      if (is_insert) begin
         rsp_tdata_in[3:0] = placed_rank;
         rsp_tdata_in[4]   = in_top_ten;
      end else begin
         rsp_tdata_in[36:5]    = read_entry.score;
         rsp_tdata_in[100:37]  = read_entry.name_low;
         rsp_tdata_in[164:101] = read_entry.name_mid;
         rsp_tdata_in[196:165] = read_entry.name_high;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (req_fire) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // hold the payload until a new beat is taken
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   a_place_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(place_vec))
      else $error("insert position is not unique");

   a_keep_prefix: assert property (@(posedge clock) disable iff (reset)
      ((keep_vec >> 1) & ~keep_vec) == '0)
      else $error("table order broken");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid_ff)
      else $error("accepted beat gave no response");

   a_rank_top: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_insert && !in_top_ten |=>
         (rsp_tdata_ff[3:0] == tkst_pkg::RANK_MAX) ||
         (WIDE_W'(rsp_tdata_ff[3:0]) == WIDE_W'(TABLE_SLOTS - 1)))
      else $error("dropped entry has wrong rank");
`endif

endmodule

/* sv/tkst_cell.sv */
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the score table: holds an entry, keeps it, takes the new
// entry, or takes the entry of its upper neighbor on an insert.
// ----------------------------------------------------------------------------
module tkst_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tkst_pkg::cell_ctrl_type ctrl,
   input  tkst_pkg::entry_type     new_entry,
   input  tkst_pkg::entry_type     prev_entry,
   output tkst_pkg::entry_type     entry_out,
   output logic                    keep_out
);

   tkst_pkg::entry_type entry_ff;
   tkst_pkg::entry_type entry_in;
   logic                keep;

   // an equal or higher score stays above the new entry; the last slot never stays
   assign keep = !ctrl.last && (entry_ff.score >= new_entry.score);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && !keep) begin
         if (ctrl.prev_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.score     <= '0;
         entry_ff.name_low  <= tkst_pkg::EMPTY_TEXT;
         entry_ff.name_mid  <= '0;
         entry_ff.name_high <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
   assign keep_out  = keep;

endmodule

/* tb/sv/top_k_score_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_score_table_tb
// Self-checking bench for the high-score table.
// ----------------------------------------------------------------------------
// A short table of directed beats covers the reset contents, reads past the
// table, extreme scores and ties. A long random run follows, with insert
// scores drawn mostly near the current contents so that entries land at
// every rank. A board model in the bench tracks the table and gives the
// expected response for every accepted request beat. The sender runs in
// bursts with gaps, and the receiver stalls on a pattern that cycles through
// several modes.
module top_k_score_table_tb;

   localparam int SLOTS        = 11;
   localparam int RANDOM_BEATS = 1250;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [63:0] ONES64 = '1;
   localparam logic [31:0] ONES32 = '1;
   localparam logic [63:0] ALT64  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [31:0] ALT32  = 32'hAAAA_AAAA;
   localparam logic signed [tkst_pkg::SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [tkst_pkg::SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

   localparam tkst_pkg::entry_type ZERO_ENTRY  = '0;
   localparam tkst_pkg::entry_type RESET_ENTRY = {32'sd0, tkst_pkg::EMPTY_TEXT, 64'd0, 32'd0};

   typedef struct packed {
      logic [tkst_pkg::RANK_W-1:0] rank;
      logic                        top;
      tkst_pkg::entry_type         e;
   } board_result_type;

   typedef struct packed {
      tkst_pkg::opcode_type         op;
      logic [tkst_pkg::INDEX_W-1:0] idx;
      tkst_pkg::entry_type          item;
      logic                         pinned;
      board_result_type             want;
   } stim_row_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [tkst_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [tkst_pkg::RSP_DATA_W-1:0] rsp_tdata;

   tkst_pkg::entry_type board [SLOTS];
   board_result_type    pending_results [$];
   stim_row_type        directed_rows [$];

   int errors      = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   int ready_phase = 0;

   top_k_score_table #(
      .TABLE_SLOTS(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Insert or read on the bench copy of the table; returns the response.
   function automatic board_result_type place_or_read(tkst_pkg::opcode_type op,
                                                      logic [tkst_pkg::INDEX_W-1:0] idx,
                                                      tkst_pkg::entry_type item);
      board_result_type res;
      int               rank;
      res = '0;
      if (op == tkst_pkg::OP_INSERT) begin
         rank = 0;
         for (int i = 0; i < SLOTS - 1; i++)
            if (board[i].score >= item.score) rank++;
         for (int i = SLOTS - 1; i > rank; i--)
            board[i] = board[i - 1];
         board[rank] = item;
         res.rank = (rank > 15) ? tkst_pkg::RANK_MAX : 4'(rank);
         res.top  = (rank + 1 < SLOTS);
      end else if (idx < SLOTS) begin
         res.e = board[idx];
      end
      return res;
   endfunction

   function automatic void add_row(tkst_pkg::opcode_type op,
                                   logic [tkst_pkg::INDEX_W-1:0] idx,
                                   tkst_pkg::entry_type item,
                                   logic pinned = 1'b0, board_result_type want = '0);
      stim_row_type row;
      row.op     = op;
      row.idx    = idx;
      row.item   = item;
      row.pinned = pinned;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   task automatic send_beat(tkst_pkg::opcode_type op, logic [tkst_pkg::INDEX_W-1:0] idx,
                            tkst_pkg::entry_type item, logic pinned,
                            board_result_type want);
      int               gap;
      board_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, item.name_high, item.name_mid, item.name_low, item.score, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = place_or_read(op, idx, item);
      pending_results.push_back(pinned ? want : predicted);
   endtask

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         errors++;
      end
   endtask

   // Receiver: cycle through always ready, coin flip, periodic and heavy stall.
   always @(posedge clock) begin
      ready_phase++;
      case ((ready_phase / 64) % 4)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= (ready_phase % 5) != 0;
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      board_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing pending, data %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("placed_rank", 64'(want.rank), 64'(rsp_tdata[3:0]));
            check_field("in_top_ten", 64'(want.top), 64'(rsp_tdata[4]));
            check_field("read_score", 64'(want.e.score[31:0]), 64'(rsp_tdata[36:5]));
            check_field("read_name_low", want.e.name_low, rsp_tdata[100:37]);
            check_field("read_name_mid", want.e.name_mid, rsp_tdata[164:101]);
            check_field("read_name_high", 64'(want.e.name_high), 64'(rsp_tdata[196:165]));
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("top_k_score_table_tb: FAIL");
         $finish;
      end
   end

   initial begin
      tkst_pkg::entry_type          item;
      tkst_pkg::opcode_type         op;
      logic [tkst_pkg::INDEX_W-1:0] idx;
      logic [31:0]                  delta;

      foreach (board[i]) board[i] = RESET_ENTRY;

      // reset contents, then reads past the table
      add_row(tkst_pkg::OP_READ, 4'd0, ZERO_ENTRY, 1'b1, {4'd0, 1'b0, RESET_ENTRY});
      add_row(tkst_pkg::OP_READ, 4'd10, ZERO_ENTRY, 1'b1, {4'd0, 1'b0, RESET_ENTRY});
      add_row(tkst_pkg::OP_READ, 4'd11, ZERO_ENTRY, 1'b1, '0);
      add_row(tkst_pkg::OP_READ, 4'd15, {SCORE_MAX, ONES64, ONES64, ONES32}, 1'b1, '0);
      // a tie with every upper slot lands in the last slot
      add_row(tkst_pkg::OP_INSERT, 4'd15, {32'sd0, ONES64, ONES64, ONES32}, 1'b1,
              {4'd10, 1'b0, ZERO_ENTRY});
      add_row(tkst_pkg::OP_READ, 4'd10, ZERO_ENTRY, 1'b1,
              {4'd0, 1'b0, {32'sd0, ONES64, ONES64, ONES32}});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {SCORE_MAX, 64'd0, 64'd0, 32'd0}, 1'b1,
              {4'd0, 1'b1, ZERO_ENTRY});
      add_row(tkst_pkg::OP_INSERT, 4'd5, {SCORE_MIN, ONES64, ONES64, ONES32}, 1'b1,
              {4'd10, 1'b0, ZERO_ENTRY});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {SCORE_MAX, ALT64, ALT64, ALT32}, 1'b1,
              {4'd1, 1'b1, ZERO_ENTRY});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {-32'sd1, ~ALT64, ~ALT64, ~ALT32});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {32'sd1, ALT64, ~ALT64, ALT32});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {32'sd0, ~ALT64, ALT64, ~ALT32});
      add_row(tkst_pkg::OP_INSERT, 4'd0, {SCORE_MIN, 64'd0, ONES64, 32'd0});
      add_row(tkst_pkg::OP_READ, 4'd0, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd1, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd2, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd3, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd9, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd10, ZERO_ENTRY);
      add_row(tkst_pkg::OP_READ, 4'd12, ZERO_ENTRY);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_beat(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].item,
                   directed_rows[r].pinned, directed_rows[r].want);

      repeat (RANDOM_BEATS) begin
         op  = ($urandom_range(0, 99) < 55) ? tkst_pkg::OP_INSERT : tkst_pkg::OP_READ;
         idx = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
         item.name_low  = {$urandom(), $urandom()};
         item.name_mid  = {$urandom(), $urandom()};
         item.name_high = $urandom();
         // mostly aim near the current contents so ranks spread and ties occur
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 3))
                  0: item.score = SCORE_MAX;
                  1: item.score = SCORE_MIN;
                  2: item.score = 32'sd0;
                  default: item.score = -32'sd1;
               endcase
            end
            1, 2, 3: begin
               item.score = $urandom();
            end
            default: begin
               delta      = $urandom_range(0, 6) - 3;
               item.score = board[$urandom_range(0, SLOTS - 1)].score + delta;
            end
         endcase
         send_beat(op, idx, item, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("top_k_score_table_tb: PASS");
      else
         $display("top_k_score_table_tb: FAIL");
      $finish;
   end

endmodule
